[rtl/vibration_pattern_sequencer_top_defines.svh]
// assertion helpers shared by the sequencer rtl
`ifndef VIBRATION_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define VIBRATION_PATTERN_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vps same-cycle check failed");

// next-cycle implication, checked out of reset
`define VPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vps next-cycle check failed");

`endif

[rtl/vps_pkg.sv]
package vps_pkg;

	// default sizes
	localparam int MAX_STEPS_DEF     = 8;
	localparam int STEP_TIME_MAX_DEF = 10000;

	// repeat handling
	localparam logic signed [7:0] REPEAT_CAP     = 8'sd100;
	localparam logic signed [7:0] REPEAT_ENDLESS = -8'sd1;

	// item modes
	localparam logic [1:0] MODE_PREPARE = 2'd0;
	localparam logic [1:0] MODE_PLAY    = 2'd1;
	localparam logic [1:0] MODE_TICK    = 2'd2;
	localparam logic [1:0] MODE_STOP    = 2'd3;

	// register indexes
	localparam logic [1:0] REG_STEP_COUNT = 2'd0;
	localparam logic [1:0] REG_REPEAT     = 2'd1;
	localparam logic [1:0] REG_STEPS_LOW  = 2'd2;
	localparam logic [1:0] REG_STEPS_HIGH = 2'd3;

	// effective configuration seen by the core
	typedef struct packed {
		logic [3:0]         count;
		logic signed [7:0]  repeats;
		logic [127:0]       steps;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic        motor_on;
		logic        busy_res;
		logic        step_start;
		logic [13:0] step_duration;
		logic [2:0]  step_now;
		logic        complete;
	} res_t;

endpackage

[rtl/vps_cfg.sv]
module vps_cfg #(
	parameter int MAX_STEPS = vps_pkg::MAX_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output vps_pkg::cfg_t       cfg
);

	logic [3:0]        count_q;
	logic signed [7:0] repeat_q;
	logic [63:0]       low_q;
	logic [63:0]       high_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 4'd1;
			repeat_q <= 8'sd0;
			low_q    <= 64'd0;
			high_q   <= 64'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vps_pkg::REG_STEP_COUNT: count_q  <= cfg_data[3:0];
				vps_pkg::REG_REPEAT:     repeat_q <= signed'(cfg_data[7:0]);
				vps_pkg::REG_STEPS_LOW:  low_q    <= cfg_data;
				vps_pkg::REG_STEPS_HIGH: high_q   <= cfg_data;
			endcase
		end
	end

	// clamp step count and repeat setting into range
	always_comb begin
		cfg.count = count_q;
		if (count_q == 4'd0)
			cfg.count = 4'd1;
		else if (count_q > 4'(MAX_STEPS))
			cfg.count = 4'(MAX_STEPS);

		cfg.repeats = repeat_q;
		if (repeat_q > vps_pkg::REPEAT_CAP)
			cfg.repeats = vps_pkg::REPEAT_CAP;
		else if (repeat_q < vps_pkg::REPEAT_ENDLESS)
			cfg.repeats = vps_pkg::REPEAT_ENDLESS;

		cfg.steps = {high_q, low_q};
	end

endmodule

[rtl/vps_core.sv]
module vps_core #(
	parameter int STEP_TIME_MAX = vps_pkg::STEP_TIME_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [1:0]     mode,
	input  logic [23:0]    total_duration,
	input  vps_pkg::cfg_t  cfg,
	output vps_pkg::res_t  res
);

	localparam logic [13:0] StepMax = 14'(STEP_TIME_MAX);

	logic              running_q;
	logic [3:0]        idx_q;
	logic [13:0]       stl_q;
	logic [23:0]       total_q;
	logic signed [7:0] rep_q;
	logic              drive_q;
	logic              final_q;

	logic              n_running;
	logic [3:0]        n_idx;
	logic [13:0]       n_stl;
	logic [23:0]       n_total;
	logic signed [7:0] n_rep;
	logic              n_drive;
	logic              n_final;

	logic              do_start;
	logic              wrap;
	logic              can_wrap;
	logic [15:0]       bits;
	logic [13:0]       len;
	logic [13:0]       dur;
	logic              started;
	logic              done;

	// next state for one item
	always_comb begin
		n_running = running_q;
		n_idx     = idx_q;
		n_stl     = stl_q;
		n_total   = total_q;
		n_rep     = rep_q;
		n_drive   = drive_q;
		n_final   = final_q;
		do_start  = 1'b0;
		wrap      = 1'b0;
		can_wrap  = 1'b0;
		bits      = 16'd0;
		len       = 14'd0;
		dur       = 14'd0;
		started   = 1'b0;
		done      = 1'b0;

		unique case (mode)
			vps_pkg::MODE_PREPARE: begin
				n_running = 1'b0;
				n_drive   = 1'b0;
				n_stl     = 14'd0;
				n_total   = total_duration;
				n_idx     = 4'd0;
				n_final   = 1'b0;
				n_rep     = (total_duration != 24'd0) ? vps_pkg::REPEAT_ENDLESS
					: cfg.repeats;
			end
			vps_pkg::MODE_PLAY: begin
				do_start = 1'b1;
			end
			vps_pkg::MODE_TICK: begin
				if (running_q && stl_q != 14'd0) begin
					n_stl = stl_q - 14'd1;
					if (stl_q == 14'd1) begin
						if (!final_q && idx_q != 4'd15)
							n_idx = idx_q + 4'd1;
						do_start = 1'b1;
					end
				end
			end
			vps_pkg::MODE_STOP: begin
				n_running = 1'b0;
				n_drive   = 1'b0;
				n_stl     = 14'd0;
			end
		endcase

		// start the current step, wrap the table or finish
		if (do_start) begin
			wrap     = final_q || (n_idx >= cfg.count);
			can_wrap = (rep_q == vps_pkg::REPEAT_ENDLESS) || (rep_q > 8'sd0);
			if (wrap && !can_wrap) begin
				n_running = 1'b0;
				n_drive   = 1'b0;
				n_stl     = 14'd0;
				done      = 1'b1;
			end else begin
				if (wrap) begin
					if (rep_q > 8'sd0)
						n_rep = rep_q - 8'sd1;
					n_idx   = 4'd0;
					n_final = 1'b0;
				end
				bits = cfg.steps[{n_idx[2:0], 4'd0} +: 16];
				len  = bits[13:0];
				if (len == 14'd0)
					len = 14'd1;
				else if (len > StepMax)
					len = StepMax;
				dur = len;
				// clamp to the remaining total time, or stretch a lone motor-on step over it up to the step maximum
				if (total_q != 24'd0) begin
					if (total_q > {10'd0, len}) begin
						if (bits[15] && cfg.count == 4'd1)
							dur = (total_q < {10'd0, StepMax}) ? total_q[13:0] : StepMax;
					end else begin
						dur = total_q[13:0];
					end
					n_total = total_q - {10'd0, dur};
					if (n_total == 24'd0) begin
						n_final = 1'b1;
						n_rep   = 8'sd0;
					end
				end
				n_stl     = dur;
				n_running = 1'b1;
				n_drive   = bits[15];
				started   = 1'b1;
			end
		end

		res.motor_on      = n_drive;
		res.busy_res      = n_running;
		res.step_start    = started;
		res.step_duration = dur;
		res.step_now      = n_running ? n_idx[2:0] : 3'd0;
		res.complete      = done;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			idx_q     <= 4'd0;
			stl_q     <= 14'd0;
			total_q   <= 24'd0;
			rep_q     <= 8'sd0;
			drive_q   <= 1'b0;
			final_q   <= 1'b0;
		end else if (fire) begin
			running_q <= n_running;
			idx_q     <= n_idx;
			stl_q     <= n_stl;
			total_q   <= n_total;
			rep_q     <= n_rep;
			drive_q   <= n_drive;
			final_q   <= n_final;
		end
	end

endmodule

[rtl/vibration_pattern_sequencer_top.sv]
// Vibration pattern sequencer.
// Input channel (in_valid / in_stall) carries one command item: prepare,
// play, a 1 ms tick or stop, with total_duration used by prepare only.
// Every input item yields exactly one result item on the output channel
// (out_valid / out_stall): motor drive, busy, step start with its
// duration, the current step index and a completion pulse.
// The pattern table, step count and repeat setting are loaded through the
// write port (cfg_we, cfg_index, cfg_data); the user must do so only while
// the block is idle, since the block itself does not enforce it.
// Each item passes one input register, then the state update into the
// result register.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item, the input
// register fills behind it and in_stall rises until the result is taken.
// Reset clears the sequencer (stopped, motor off, step 0, no total time),
// loads a step count of one, no repeats and an all-zero table, and empties
// both registers; no clearing pass is needed.
`include "vibration_pattern_sequencer_top_defines.svh"

module vibration_pattern_sequencer_top #(
	parameter int MAX_STEPS     = vps_pkg::MAX_STEPS_DEF,
	parameter int STEP_TIME_MAX = vps_pkg::STEP_TIME_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [23:0] total_duration,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        motor_on,
	output logic        busy_res,
	output logic        step_start,
	output logic [13:0] step_duration,
	output logic [2:0]  step_now,
	output logic        complete
);

	logic          valid_s1;
	logic [1:0]    mode_s1;
	logic [23:0]   total_s1;
	logic          valid_s2;
	vps_pkg::res_t res_s2;
	vps_pkg::cfg_t cfg;
	vps_pkg::res_t res;
	logic          advance;
	logic          fire;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1  <= mode;
			total_s1 <= total_duration;
		end
	end

	vps_cfg #(
		.MAX_STEPS(MAX_STEPS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	vps_core #(
		.STEP_TIME_MAX(STEP_TIME_MAX)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.mode(mode_s1),
		.total_duration(total_s1),
		.cfg(cfg),
		.res(res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign motor_on      = res_s2.motor_on;
	assign busy_res      = res_s2.busy_res;
	assign step_start    = res_s2.step_start;
	assign step_duration = res_s2.step_duration;
	assign step_now      = res_s2.step_now;
	assign complete      = res_s2.complete;

	// result consistency and stall behavior
	`VPS_ASSERT_NOW(a_start_xor_done, clk, arst_n, valid_s2, !(res_s2.step_start && res_s2.complete))
	`VPS_ASSERT_NOW(a_start_has_dur, clk, arst_n, valid_s2 && res_s2.step_start, res_s2.step_duration != 14'd0 && res_s2.busy_res)
	`VPS_ASSERT_NOW(a_motor_needs_busy, clk, arst_n, valid_s2 && res_s2.motor_on, res_s2.busy_res)
	`VPS_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !advance, valid_s1)

endmodule
